// ===== design/kmaa_pkg.sv =====
// Shared types and constants for the k-means assign and accumulate block.
package kmaa_pkg;

    // Block dimensions.
    localparam int NUM_CLUSTERS = 4;
    localparam int MAX_POINTS   = 1048576;
    localparam int COORD_BITS   = 16;

    // Derived widths.
    localparam int LBL_W     = 2;
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int SUM_W     = COORD_BITS + CNT_W - 1;
    localparam int DIST_W    = 2 * COORD_BITS + 1;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = $clog2(COORD_BITS);

    // Result kinds.
    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Input request payload.
    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [LBL_W-1:0]      prev_cluster;
        logic                  last_point;
    } in_t;

    // Result request payload.
    typedef struct packed {
        logic                  kind;
        logic [LBL_W-1:0]      cluster;
        logic                  changed;
        logic [COORD_BITS-1:0] mean_x;
        logic [COORD_BITS-1:0] mean_y;
        logic [CNT_W-1:0]      member_count;
        logic                  cluster_empty;
        logic                  any_changed;
        logic                  last_result;
    } out_t;

    // Search token that walks along the cell chain.
    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [LBL_W-1:0]      start;
        logic [LBL_W-1:0]      best;
        logic [DIST_W-1:0]     best_d;
        logic                  best_v;
    } tok_t;

    // Control from the sequencer to every cell.
    typedef struct packed {
        logic                  commit;
        logic [LBL_W-1:0]      label;
        logic [COORD_BITS-1:0] pt_x;
        logic [COORD_BITS-1:0] pt_y;
        logic                  clear;
        logic                  wr_x;
        logic                  wr_y;
        logic [COORD_BITS-1:0] wr_data;
    } cell_ctrl_t;

    // Status of one cell, read during the summary phase.
    typedef struct packed {
        logic [COORD_BITS-1:0] cen_x;
        logic [COORD_BITS-1:0] cen_y;
        logic [SUM_W-1:0]      sum_x;
        logic [SUM_W-1:0]      sum_y;
        logic [CNT_W-1:0]      count;
    } cell_stat_t;

endpackage

// ===== design/kmaa_cell.sv =====
// One cluster cell: centroid, distance stage, compare stage and accumulators.
module kmaa_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [kmaa_pkg::LBL_W-1:0] cell_idx,
    input  logic                    tok_in_valid,
    input  kmaa_pkg::tok_t          tok_in,
    output logic                    tok_out_valid,
    output kmaa_pkg::tok_t          tok_out,
    input  kmaa_pkg::cell_ctrl_t    ctrl,
    output kmaa_pkg::cell_stat_t    stat
);
    import kmaa_pkg::*;

    logic [COORD_BITS-1:0]   cen_x_reg, cen_x_next;
    logic [COORD_BITS-1:0]   cen_y_reg, cen_y_next;
    logic [SUM_W-1:0]        sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]        sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic                    s1_valid_reg;
    tok_t                    s1_tok_reg;
    logic [2*COORD_BITS-1:0] sqx_reg, sqx_next;
    logic [2*COORD_BITS-1:0] sqy_reg, sqy_next;

    logic                    s2_valid_reg;
    tok_t                    s2_tok_reg, s2_tok_next;

    logic [COORD_BITS-1:0]   dx, dy;
    logic [DIST_W-1:0]       dist_sum;
    logic                    take;

    // Stage one: absolute differences and their squares.
    always_comb begin
        dx = (tok_in.px > cen_x_reg) ? (tok_in.px - cen_x_reg) : (cen_x_reg - tok_in.px);
        dy = (tok_in.py > cen_y_reg) ? (tok_in.py - cen_y_reg) : (cen_y_reg - tok_in.py);
        sqx_next = dx * dx;
        sqy_next = dy * dy;
    end

    // Stage two: squared distance and the running best. A tie keeps the
    // starting label, otherwise the lowest index with the minimum wins.
    always_comb begin
        dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        take = !s1_tok_reg.best_v || (dist_sum < s1_tok_reg.best_d) ||
               ((dist_sum == s1_tok_reg.best_d) && (s1_tok_reg.start == cell_idx));
        s2_tok_next = s1_tok_reg;
        if (take) begin
            s2_tok_next.best   = cell_idx;
            s2_tok_next.best_d = dist_sum;
            s2_tok_next.best_v = 1'b1;
        end
    end

    // Centroid writes and accumulator updates; a full count freezes the accumulators.
    always_comb begin
        cen_x_next = ctrl.wr_x ? ctrl.wr_data : cen_x_reg;
        cen_y_next = ctrl.wr_y ? ctrl.wr_data : cen_y_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        count_next = count_reg;
        if (ctrl.clear) begin
            sum_x_next = '0;
            sum_y_next = '0;
            count_next = '0;
        end else if (ctrl.commit && (ctrl.label == cell_idx) &&
                     (count_reg < CNT_W'(MAX_POINTS))) begin
            sum_x_next = sum_x_reg + {{(SUM_W-COORD_BITS){1'b0}}, ctrl.pt_x};
            sum_y_next = sum_y_reg + {{(SUM_W-COORD_BITS){1'b0}}, ctrl.pt_y};
            count_next = count_reg + CNT_W'(1);
        end
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_x_reg    <= '0;
            cen_y_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            cen_x_reg    <= cen_x_next;
            cen_y_reg    <= cen_y_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            count_reg    <= count_next;
            s1_valid_reg <= tok_in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Token payload registers.
    always_ff @(posedge aclk) begin
        s1_tok_reg <= tok_in;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        s2_tok_reg <= s2_tok_next;
    end

    assign tok_out_valid = s2_valid_reg;
    assign tok_out       = s2_tok_reg;

    always_comb begin
        stat.cen_x = cen_x_reg;
        stat.cen_y = cen_y_reg;
        stat.sum_x = sum_x_reg;
        stat.sum_y = sum_y_reg;
        stat.count = count_reg;
    end

endmodule

// ===== design/kmaa_div.sv =====
// Restoring divider producing both mean coordinates, one quotient bit a cycle.
module kmaa_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [kmaa_pkg::SUM_W-1:0]    sum_x,
    input  logic [kmaa_pkg::SUM_W-1:0]    sum_y,
    input  logic [kmaa_pkg::CNT_W-1:0]    count,
    output logic                          done,
    output logic [kmaa_pkg::COORD_BITS-1:0] quot_x,
    output logic [kmaa_pkg::COORD_BITS-1:0] quot_y
);
    import kmaa_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]      rem_x_reg, rem_x_next;
    logic [CNT_W-1:0]      rem_y_reg, rem_y_next;
    logic [COORD_BITS-1:0] dvd_x_reg, dvd_x_next;
    logic [COORD_BITS-1:0] dvd_y_reg, dvd_y_next;
    logic [CNT_W-1:0]      div_reg, div_next;
    logic [CNT_W:0]        step_x, step_y;

    // One restoring step: returns the quotient bit over the new remainder.
    function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                                input logic in_bit,
                                                input logic [CNT_W-1:0] d);
        logic [CNT_W:0] trial;
        logic [CNT_W:0] diff;
        trial = {rem, in_bit};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            div_step = {1'b1, diff[CNT_W-1:0]};
        end else begin
            div_step = {1'b0, trial[CNT_W-1:0]};
        end
    endfunction

    // The high part of the sum is below the divisor, so the quotient
    // fits the coordinate width and needs one step per coordinate bit.
    always_comb begin
        step_x     = div_step(rem_x_reg, dvd_x_reg[COORD_BITS-1], div_reg);
        step_y     = div_step(rem_y_reg, dvd_y_reg[COORD_BITS-1], div_reg);
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        dvd_x_next = dvd_x_reg;
        dvd_y_next = dvd_y_reg;
        div_next   = div_reg;
        if (start) begin
            busy_next  = 1'b1;
            step_next  = STEP_W'(COORD_BITS - 1);
            rem_x_next = {1'b0, sum_x[SUM_W-1:COORD_BITS]};
            rem_y_next = {1'b0, sum_y[SUM_W-1:COORD_BITS]};
            dvd_x_next = sum_x[COORD_BITS-1:0];
            dvd_y_next = sum_y[COORD_BITS-1:0];
            div_next   = count;
        end else if (busy_reg) begin
            rem_x_next = step_x[CNT_W-1:0];
            rem_y_next = step_y[CNT_W-1:0];
            dvd_x_next = {dvd_x_reg[COORD_BITS-2:0], step_x[CNT_W]};
            dvd_y_next = {dvd_y_reg[COORD_BITS-2:0], step_y[CNT_W]};
            step_next  = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        dvd_x_reg <= dvd_x_next;
        dvd_y_reg <= dvd_y_next;
        div_reg   <= div_next;
    end

    assign done   = done_reg;
    assign quot_x = dvd_x_reg;
    assign quot_y = dvd_y_reg;

endmodule

// ===== design/kmeans_assign_accumulate.sv =====
// Top level: k-means label assignment over a cell chain, with pass summaries.
//
//  Channel   Ports                        Carries
//  input     s_valid s_ready s_data       one point with its previous label
//  result    m_valid m_ready m_data       point label, or one cluster summary
//  config    cfg_we cfg_index cfg_data    centroid coordinates, index 0 to 7
//
// A point walks through four cells of two stages each and is committed when
// it leaves the chain; its label request is registered in ST_PT once the
// result channel is free, and the next point is taken back in ST_IDLE.
// On the last point of a pass each summary waits for the one-bit-a-cycle
// divider; the accumulators clear after the last one. Reset clears control,
// centroid and accumulator state; a stalled result lets one more point in.
module kmeans_assign_accumulate (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  kmaa_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output kmaa_pkg::out_t                    m_data,
    input  logic                              cfg_we,
    input  logic [kmaa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmaa_pkg::COORD_BITS-1:0]   cfg_data
);
    import kmaa_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHAIN = 3'd1;
    localparam logic [2:0] ST_PT    = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [LBL_W-1:0]      idx_reg, idx_next;
    logic                  pass_ch_reg, pass_ch_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic [COORD_BITS-1:0] pt_x_reg, pt_y_reg;
    logic [LBL_W-1:0]      prev_reg;
    logic                  last_reg;
    logic [LBL_W-1:0]      lbl_reg, lbl_next;
    logic                  chg_reg, chg_next;

    logic                  accept, out_free, commit, clear, div_start, div_done;
    logic                  new_chg;
    logic [COORD_BITS-1:0] quot_x, quot_y;
    logic [LBL_W-1:0]      start_lbl;
    out_t                  pt_res, sum_res;
    cell_stat_t            cur;

    logic                  chain_valid [0:NUM_CLUSTERS];
    tok_t                  chain_tok   [0:NUM_CLUSTERS];
    cell_stat_t            stat        [0:NUM_CLUSTERS-1];
    cell_ctrl_t            ctrl        [0:NUM_CLUSTERS-1];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // An out-of-range previous label starts the search at the last cluster.
    assign start_lbl = (int'(s_data.prev_cluster) < NUM_CLUSTERS) ?
                       s_data.prev_cluster : LBL_W'(NUM_CLUSTERS - 1);

    // Token that enters the head of the chain.
    always_comb begin
        chain_valid[0]      = accept;
        chain_tok[0].px     = s_data.point_x;
        chain_tok[0].py     = s_data.point_y;
        chain_tok[0].start  = start_lbl;
        chain_tok[0].best   = '0;
        chain_tok[0].best_d = '0;
        chain_tok[0].best_v = 1'b0;
    end

    // The cell chain.
    for (genvar j = 0; j < NUM_CLUSTERS; j++) begin : g_cell
        always_comb begin
            ctrl[j].commit  = commit;
            ctrl[j].label   = chain_tok[NUM_CLUSTERS].best;
            ctrl[j].pt_x    = pt_x_reg;
            ctrl[j].pt_y    = pt_y_reg;
            ctrl[j].clear   = clear;
            ctrl[j].wr_x    = cfg_we && (cfg_index == CFG_IDX_W'(2 * j));
            ctrl[j].wr_y    = cfg_we && (cfg_index == CFG_IDX_W'(2 * j + 1));
            ctrl[j].wr_data = cfg_data;
        end

        kmaa_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cell_idx      (LBL_W'(j)),
            .tok_in_valid  (chain_valid[j]),
            .tok_in        (chain_tok[j]),
            .tok_out_valid (chain_valid[j+1]),
            .tok_out       (chain_tok[j+1]),
            .ctrl          (ctrl[j]),
            .stat          (stat[j])
        );
    end

    assign cur = stat[idx_reg];

    kmaa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum_x   (cur.sum_x),
        .sum_y   (cur.sum_y),
        .count   (cur.count),
        .done    (div_done),
        .quot_x  (quot_x),
        .quot_y  (quot_y)
    );

    // Point assignment result.
    always_comb begin
        pt_res               = '0;
        pt_res.kind          = KIND_POINT;
        pt_res.cluster       = lbl_reg;
        pt_res.changed       = chg_reg;
        pt_res.last_result   = !last_reg;
    end

    // Cluster summary; an empty cluster returns its configured centroid.
    always_comb begin
        sum_res               = '0;
        sum_res.kind          = KIND_SUMMARY;
        sum_res.cluster       = idx_reg;
        sum_res.cluster_empty = (cur.count == '0);
        sum_res.mean_x        = sum_res.cluster_empty ? cur.cen_x : quot_x;
        sum_res.mean_y        = sum_res.cluster_empty ? cur.cen_y : quot_y;
        sum_res.member_count  = cur.count;
        sum_res.any_changed   = pass_ch_reg;
        sum_res.last_result   = (idx_reg == LBL_W'(NUM_CLUSTERS - 1));
    end

    assign new_chg = (chain_tok[NUM_CLUSTERS].best != prev_reg);

    // Sequencer: search, commit, label request, then the summaries.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pass_ch_next = pass_ch_reg;
        lbl_next     = lbl_reg;
        chg_next     = chg_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        commit       = 1'b0;
        clear        = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CHAIN;
                end
            end
            ST_CHAIN: begin
                if (chain_valid[NUM_CLUSTERS]) begin
                    commit   = 1'b1;
                    lbl_next = chain_tok[NUM_CLUSTERS].best;
                    chg_next = new_chg;
                    if (new_chg) begin
                        pass_ch_next = 1'b1;
                    end
                    state_next = ST_PT;
                end
            end
            ST_PT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pt_res;
                    if (last_reg) begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LOAD: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = sum_res;
                    if (idx_reg == LBL_W'(NUM_CLUSTERS - 1)) begin
                        clear        = 1'b1;
                        pass_ch_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + LBL_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pass_ch_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pass_ch_reg <= pass_ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pt_x_reg <= s_data.point_x;
            pt_y_reg <= s_data.point_y;
            prev_reg <= s_data.prev_cluster;
            last_reg <= s_data.last_point;
        end
        lbl_reg    <= lbl_next;
        chg_reg    <= chg_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
